FILE: sv/obb_pkg.sv
`timescale 1ns / 1ps

package obb_pkg;

    localparam int EXT_W      = 25;
    localparam int POS_W      = 32;
    localparam int QUAT_W     = 16;
    localparam int PROD_W     = 2 * QUAT_W;
    localparam int MAT_W      = PROD_W + 2;
    localparam int TERM_W     = MAT_W + EXT_W;
    localparam int SUM_W      = TERM_W + 2;
    localparam int FRAC_SHIFT = 27;
    localparam int MAG_W      = SUM_W - FRAC_SHIFT + 1;
    localparam int WIDE_W     = MAG_W + 3;

    localparam logic [EXT_W-1:0] EXT_RESET = 25'd65536;

    typedef enum logic [1:0] {
        REG_HALF_EXTENT_X = 2'd0,
        REG_HALF_EXTENT_Y = 2'd1,
        REG_HALF_EXTENT_Z = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic signed [QUAT_W-1:0] quat_w;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
    } in_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] min_x;
        logic signed [POS_W-1:0] min_y;
        logic signed [POS_W-1:0] min_z;
        logic signed [POS_W-1:0] max_x;
        logic signed [POS_W-1:0] max_y;
        logic signed [POS_W-1:0] max_z;
    } out_item_t;

    // Load enables of the per-axis stages.
    typedef struct packed {
        logic en3;
        logic en4;
        logic en5;
        logic en6;
    } axis_ctrl_t;

endpackage

FILE: sv/oriented_box_bounds.sv
`timescale 1ns / 1ps

// Axis-aligned bounds of a box with configured half-extents, posed by a
// center position and a rotation quaternion.
// Input channel: in_valid/in_ready with in_data; output channel:
// out_valid/out_ready with out_data. One result per input transfer.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Writes are to be made only while the block is empty; the block does not enforce it.
// The block is a six-stage pipeline and takes one pose every cycle unless the
// receiver stalls with every stage full. The last stage is the output register.
// Each stage loads whenever it is empty or the one after it moves, so when
// the receiver stalls, bubbles close up and input stops only once every
// stage holds an item. Nothing is dropped or repeated.
// Reset empties the pipeline and sets each half-extent to 1.0.

module oriented_box_bounds
    import obb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [EXT_W-1:0] cfg_data
);

    localparam logic signed [MAT_W-1:0] ONE = MAT_W'(64'sd134217728);

    logic [EXT_W-1:0] hx_reg, hy_reg, hz_reg;
    logic [6:1]       vld_reg;
    logic [6:1]       en;
    axis_ctrl_t       ctrl;

    logic signed [POS_W-1:0]  p1x_reg, p1y_reg, p1z_reg;
    logic signed [POS_W-1:0]  p2x_reg, p2y_reg, p2z_reg;
    logic signed [PROD_W-1:0] wx_reg, wy_reg, wz_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PROD_W-1:0] xy_reg, xz_reg, yz_reg;
    logic [MAT_W-1:0]         nabs_reg [3][3];
    logic signed [MAT_W-1:0]  n_next   [3][3];

    logic signed [POS_W-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;

    function automatic logic signed [MAT_W-1:0] ext(input logic signed [PROD_W-1:0] v);
        ext = MAT_W'(v);
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hx_reg <= EXT_RESET;
            hy_reg <= EXT_RESET;
            hz_reg <= EXT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_HALF_EXTENT_X: hx_reg <= cfg_data;
                REG_HALF_EXTENT_Y: hy_reg <= cfg_data;
                REG_HALF_EXTENT_Z: hz_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Ready ripples back from the output: a stage loads when empty or draining.
    always_comb
    begin
        en[6] = !vld_reg[6] || out_ready;
        for (int k = 5; k >= 1; k--)
            en[k] = !vld_reg[k] || en[k+1];
    end

    assign in_ready = en[1];
    assign ctrl.en3 = en[3];
    assign ctrl.en4 = en[4];
    assign ctrl.en5 = en[5];
    assign ctrl.en6 = en[6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (en[1])
                vld_reg[1] <= in_valid;
            for (int k = 2; k <= 6; k++)
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            wx_reg  <= in_data.quat_w * in_data.quat_x;
            wy_reg  <= in_data.quat_w * in_data.quat_y;
            wz_reg  <= in_data.quat_w * in_data.quat_z;
            xx_reg  <= in_data.quat_x * in_data.quat_x;
            yy_reg  <= in_data.quat_y * in_data.quat_y;
            zz_reg  <= in_data.quat_z * in_data.quat_z;
            xy_reg  <= in_data.quat_x * in_data.quat_y;
            xz_reg  <= in_data.quat_x * in_data.quat_z;
            yz_reg  <= in_data.quat_y * in_data.quat_z;
            p1x_reg <= in_data.pos_x;
            p1y_reg <= in_data.pos_y;
            p1z_reg <= in_data.pos_z;
        end
        if (en[2])
        begin
            for (int a = 0; a < 3; a++)
                for (int b = 0; b < 3; b++)
                    nabs_reg[a][b] <= n_next[a][b][MAT_W-1] ? MAT_W'(-n_next[a][b])
                                                             : MAT_W'(n_next[a][b]);
            p2x_reg <= p1x_reg;
            p2y_reg <= p1y_reg;
            p2z_reg <= p1z_reg;
        end
    end

    // Rotation offset 2w(q x v) + 2q x (q x v) as a matrix, plus the identity
    // scaled to the same fixed point so that v folds into one product.
    always_comb
    begin
        n_next[0][0] = ONE - ext(yy_reg) - ext(zz_reg);
        n_next[0][1] = ext(xy_reg) - ext(wz_reg);
        n_next[0][2] = ext(wy_reg) + ext(xz_reg);
        n_next[1][0] = ext(wz_reg) + ext(xy_reg);
        n_next[1][1] = ONE - ext(xx_reg) - ext(zz_reg);
        n_next[1][2] = ext(yz_reg) - ext(wx_reg);
        n_next[2][0] = ext(xz_reg) - ext(wy_reg);
        n_next[2][1] = ext(wx_reg) + ext(yz_reg);
        n_next[2][2] = ONE - ext(xx_reg) - ext(yy_reg);
    end

    obb_axis u_axis_x (
        .clk   (clk),
        .ctrl  (ctrl),
        .nabs0 (nabs_reg[0][0]),
        .nabs1 (nabs_reg[0][1]),
        .nabs2 (nabs_reg[0][2]),
        .h0    (hx_reg),
        .h1    (hy_reg),
        .h2    (hz_reg),
        .pos   (p2x_reg),
        .lo    (lo_x),
        .hi    (hi_x)
    );

    obb_axis u_axis_y (
        .clk   (clk),
        .ctrl  (ctrl),
        .nabs0 (nabs_reg[1][0]),
        .nabs1 (nabs_reg[1][1]),
        .nabs2 (nabs_reg[1][2]),
        .h0    (hx_reg),
        .h1    (hy_reg),
        .h2    (hz_reg),
        .pos   (p2y_reg),
        .lo    (lo_y),
        .hi    (hi_y)
    );

    obb_axis u_axis_z (
        .clk   (clk),
        .ctrl  (ctrl),
        .nabs0 (nabs_reg[2][0]),
        .nabs1 (nabs_reg[2][1]),
        .nabs2 (nabs_reg[2][2]),
        .h0    (hx_reg),
        .h1    (hy_reg),
        .h2    (hz_reg),
        .pos   (p2z_reg),
        .lo    (lo_z),
        .hi    (hi_z)
    );

    assign out_valid      = vld_reg[6];
    assign out_data.min_x = lo_x;
    assign out_data.min_y = lo_y;
    assign out_data.min_z = lo_z;
    assign out_data.max_x = hi_x;
    assign out_data.max_y = hi_y;
    assign out_data.max_z = hi_z;

endmodule

FILE: sv/obb_axis.sv
`timescale 1ns / 1ps

module obb_axis
    import obb_pkg::*;
(
    input  logic                    clk,
    input  axis_ctrl_t              ctrl,
    input  logic [MAT_W-1:0]        nabs0,
    input  logic [MAT_W-1:0]        nabs1,
    input  logic [MAT_W-1:0]        nabs2,
    input  logic [EXT_W-1:0]        h0,
    input  logic [EXT_W-1:0]        h1,
    input  logic [EXT_W-1:0]        h2,
    input  logic signed [POS_W-1:0] pos,
    output logic signed [POS_W-1:0] lo,
    output logic signed [POS_W-1:0] hi
);

    localparam logic [SUM_W-1:0] HALF    = SUM_W'(1) << (FRAC_SHIFT - 1);
    localparam logic [SUM_W-1:0] HALF_M1 = HALF - SUM_W'(1);
    localparam logic signed [WIDE_W-1:0] SAT_MAX = WIDE_W'(64'sh7FFFFFFF);
    localparam logic signed [WIDE_W-1:0] SAT_MIN = -WIDE_W'(64'sh80000000);

    logic [TERM_W-1:0]       t0_reg, t1_reg, t2_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [MAG_W-1:0]        hi_mag_reg, lo_mag_reg;
    logic signed [POS_W-1:0] pos3_reg, pos4_reg, pos5_reg;
    logic signed [POS_W-1:0] lo_reg, hi_reg;

    logic [SUM_W-1:0]        hi_sum, lo_sum;
    logic signed [WIDE_W-1:0] pos_wide, hi_wide, lo_wide;
    logic signed [POS_W-1:0] lo_next, hi_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.en3)
        begin
            t0_reg   <= TERM_W'(nabs0) * TERM_W'(h0);
            t1_reg   <= TERM_W'(nabs1) * TERM_W'(h1);
            t2_reg   <= TERM_W'(nabs2) * TERM_W'(h2);
            pos3_reg <= pos;
        end
        if (ctrl.en4)
        begin
            sum_reg  <= SUM_W'(t0_reg) + SUM_W'(t1_reg) + SUM_W'(t2_reg);
            pos4_reg <= pos3_reg;
        end
        if (ctrl.en5)
        begin
            hi_mag_reg <= MAG_W'(hi_sum >> FRAC_SHIFT);
            lo_mag_reg <= MAG_W'(lo_sum >> FRAC_SHIFT);
            pos5_reg   <= pos4_reg;
        end
        if (ctrl.en6)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    // The bound is monotone in the summed offset, so the extreme corners are
    // the ones whose signs make every term add up with the same sign.
    always_comb
    begin
        hi_sum   = sum_reg + HALF;
        lo_sum   = sum_reg + HALF_M1;
        pos_wide = WIDE_W'(pos5_reg);
        hi_wide  = pos_wide + $signed({3'b000, hi_mag_reg});
        lo_wide  = pos_wide - $signed({3'b000, lo_mag_reg});
        if (hi_wide > SAT_MAX)
            hi_next = POS_W'(SAT_MAX);
        else
            hi_next = POS_W'(hi_wide);
        if (lo_wide < SAT_MIN)
            lo_next = POS_W'(SAT_MIN);
        else
            lo_next = POS_W'(lo_wide);
    end

    assign lo = lo_reg;
    assign hi = hi_reg;

endmodule
